@@ rtl/hqr_pkg.sv @@
// Shared constants and types for the 3x3 Householder QR block.
package hqr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 24;
  localparam int UNIT_FRAC  = 28;
  localparam int EW         = 34;

  typedef logic signed [EW-1:0] ent_t;
  typedef ent_t rows_t [3][6];
  typedef ent_t col_t [3];

endpackage

@@ rtl/hqr_reflect.sv @@
// One pipelined Householder reflection that clears lanes 1 and 2 of a column.
module hqr_reflect (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  hqr_pkg::rows_t in_rows,
  input  hqr_pkg::col_t  in_col,
  input  logic          in_deg,
  output logic          out_vld,
  output hqr_pkg::rows_t out_rows,
  output logic          out_deg
);

  localparam int UF        = hqr_pkg::UNIT_FRAC;
  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 29;
  localparam int S_SQ1     = 6;
  localparam int S_VM      = S_SQ1 + SQ_STEPS + 1;
  localparam int S_VSQ     = S_VM + 1;
  localparam int S_SQ2     = S_VSQ + 1;
  localparam int S_DIV     = S_SQ2 + SQ_STEPS + 1;
  localparam int S_U       = S_DIV + DIV_STEPS + 1;
  localparam int S_UU      = S_U + 1;
  localparam int S_H       = S_UU + 1;
  localparam int S_PR      = S_H + 1;
  localparam int LAST      = S_PR + 1;

  typedef struct {
    hqr_pkg::ent_t       a [3][6];
    hqr_pkg::ent_t       c [3];
    logic                deg_in;
    logic                zd;
    logic                ng [3];
    logic [33:0]         mg [3];
    logic [33:0]         mx;
    logic [5:0]          sh;
    logic                left;
    logic [57:0]         sq [3];
    logic [61:0]         rad;
    logic [34:0]         srem;
    logic [30:0]         root;
    logic [30:0]         vm [3];
    logic [61:0]         vsq [3];
    logic [30:0]         vn;
    logic [31:0]         drem [3];
    logic [28:0]         dlow [3];
    logic [28:0]         quo [3];
    logic signed [29:0]  u [3];
    logic signed [59:0]  uu [3][3];
    logic signed [30:0]  h [3][3];
    logic signed [64:0]  pr [3][3][6];
  } stg_t;

  stg_t         st_r   [LAST+1];
  stg_t         st_nxt [LAST+1];
  logic [LAST:0] vld_r;

  function automatic stg_t sqrt_step(stg_t s);
    logic [34:0] rem;
    logic [34:0] trial;
    sqrt_step = s;
    rem = {s.srem[32:0], s.rad[61:60]};
    trial = {2'b00, s.root, 2'b01};
    sqrt_step.rad = {s.rad[59:0], 2'b00};
    if (rem >= trial) begin
      sqrt_step.srem = rem - trial;
      sqrt_step.root = {s.root[29:0], 1'b1};
    end else begin
      sqrt_step.srem = rem;
      sqrt_step.root = {s.root[29:0], 1'b0};
    end
  endfunction

  function automatic stg_t div_step(stg_t s);
    logic [31:0] rem;
    div_step = s;
    for (int k = 0; k < 3; k++) begin
      rem = {s.drem[k][30:0], s.dlow[k][28]};
      div_step.dlow[k] = {s.dlow[k][27:0], 1'b0};
      if (rem >= {1'b0, s.vn}) begin
        div_step.drem[k] = rem - {1'b0, s.vn};
        div_step.quo[k] = {s.quo[k][27:0], 1'b1};
      end else begin
        div_step.drem[k] = rem;
        div_step.quo[k] = {s.quo[k][27:0], 1'b0};
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAST-1:0], in_vld};
    end
  end

  for (genvar n = 0; n <= LAST; n++) begin : g_stage
    always_ff @(posedge clk) begin
      st_r[n] <= st_nxt[n];
    end
  end

  always_comb begin
    st_nxt[0] = st_r[0];
    st_nxt[0].a = in_rows;
    st_nxt[0].c = in_col;
    st_nxt[0].deg_in = in_deg;
  end

  always_comb begin
    st_nxt[1] = st_r[0];
    for (int k = 0; k < 3; k++) begin
      st_nxt[1].ng[k] = st_r[0].c[k][hqr_pkg::EW-1];
      st_nxt[1].mg[k] = st_r[0].c[k][hqr_pkg::EW-1] ? 34'(-st_r[0].c[k]) : 34'(st_r[0].c[k]);
    end
  end

  always_comb begin : max_c
    logic [33:0] m;
    st_nxt[2] = st_r[1];
    m = st_r[1].mg[0];
    if (st_r[1].mg[1] > m) begin
      m = st_r[1].mg[1];
    end
    if (st_r[1].mg[2] > m) begin
      m = st_r[1].mg[2];
    end
    st_nxt[2].mx = m;
  end

  always_comb begin : prio_c
    logic [5:0] e;
    st_nxt[3] = st_r[2];
    e = '0;
    for (int b = 0; b < 34; b++) begin
      if (st_r[2].mx[b]) begin
        e = 6'(b);
      end
    end
    st_nxt[3].zd = (st_r[2].mx == '0);
    st_nxt[3].left = (e < 6'(UF));
    st_nxt[3].sh = (e < 6'(UF)) ? 6'(UF) - e : e - 6'(UF);
  end

  always_comb begin
    st_nxt[4] = st_r[3];
    for (int k = 0; k < 3; k++) begin
      st_nxt[4].mg[k] = st_r[3].left ? (st_r[3].mg[k] << st_r[3].sh)
                                     : (st_r[3].mg[k] >> st_r[3].sh);
    end
  end

  always_comb begin
    st_nxt[5] = st_r[4];
    for (int k = 0; k < 3; k++) begin
      st_nxt[5].sq[k] = 58'(st_r[4].mg[k][28:0]) * 58'(st_r[4].mg[k][28:0]);
    end
  end

  always_comb begin
    st_nxt[S_SQ1] = st_r[S_SQ1-1];
    st_nxt[S_SQ1].rad = 62'(st_r[S_SQ1-1].sq[0]) + 62'(st_r[S_SQ1-1].sq[1])
                      + 62'(st_r[S_SQ1-1].sq[2]);
    st_nxt[S_SQ1].srem = '0;
    st_nxt[S_SQ1].root = '0;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq1
    always_comb begin
      st_nxt[S_SQ1+1+k] = sqrt_step(st_r[S_SQ1+k]);
    end
  end

  always_comb begin
    st_nxt[S_VM] = st_r[S_VM-1];
    for (int k = 0; k < 3; k++) begin
      st_nxt[S_VM].vm[k] = st_r[S_VM-1].mg[k][30:0];
    end
    st_nxt[S_VM].vm[0] = st_r[S_VM-1].mg[0][30:0] + st_r[S_VM-1].root;
  end

  always_comb begin
    st_nxt[S_VSQ] = st_r[S_VSQ-1];
    for (int k = 0; k < 3; k++) begin
      st_nxt[S_VSQ].vsq[k] = 62'(st_r[S_VSQ-1].vm[k]) * 62'(st_r[S_VSQ-1].vm[k]);
    end
  end

  always_comb begin
    st_nxt[S_SQ2] = st_r[S_SQ2-1];
    st_nxt[S_SQ2].rad = st_r[S_SQ2-1].vsq[0] + st_r[S_SQ2-1].vsq[1]
                      + st_r[S_SQ2-1].vsq[2];
    st_nxt[S_SQ2].srem = '0;
    st_nxt[S_SQ2].root = '0;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq2
    always_comb begin
      st_nxt[S_SQ2+1+k] = sqrt_step(st_r[S_SQ2+k]);
    end
  end

  always_comb begin : num_c
    logic [59:0] num;
    st_nxt[S_DIV] = st_r[S_DIV-1];
    st_nxt[S_DIV].vn = st_r[S_DIV-1].root;
    for (int k = 0; k < 3; k++) begin
      num = {1'b0, st_r[S_DIV-1].vm[k], 28'd0} + 60'(st_r[S_DIV-1].root >> 1);
      st_nxt[S_DIV].drem[k] = {1'b0, num[59:29]};
      st_nxt[S_DIV].dlow[k] = num[28:0];
      st_nxt[S_DIV].quo[k] = '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_comb begin
      st_nxt[S_DIV+1+k] = div_step(st_r[S_DIV+k]);
    end
  end

  always_comb begin : unit_c
    logic signed [29:0] ux;
    st_nxt[S_U] = st_r[S_U-1];
    for (int k = 0; k < 3; k++) begin
      ux = $signed(30'(st_r[S_U-1].quo[k]));
      if (st_r[S_U-1].zd) begin
        st_nxt[S_U].u[k] = '0;
      end else begin
        st_nxt[S_U].u[k] = st_r[S_U-1].ng[k] ? -ux : ux;
      end
    end
  end

  always_comb begin : uu_c
    logic signed [59:0] p;
    st_nxt[S_UU] = st_r[S_UU-1];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p = st_r[S_UU-1].u[i] * st_r[S_UU-1].u[j];
        st_nxt[S_UU].uu[i][j] = p <<< 1;
      end
    end
  end

  always_comb begin : h_c
    logic signed [59:0] hv;
    st_nxt[S_H] = st_r[S_H-1];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        hv = (st_r[S_H-1].uu[i][j] + (60'sd1 <<< (UF-1))) >>> UF;
        st_nxt[S_H].h[i][j] = ((i == j) ? (31'sd1 <<< UF) : 31'sd0) - 31'(hv);
      end
    end
  end

  always_comb begin
    st_nxt[S_PR] = st_r[S_PR-1];
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 6; j++) begin
          st_nxt[S_PR].pr[i][k][j] = st_r[S_PR-1].h[i][k] * st_r[S_PR-1].a[k][j];
        end
      end
    end
  end

  always_comb begin : sum_c
    logic signed [66:0] acc;
    st_nxt[LAST] = st_r[LAST-1];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 6; j++) begin
        acc = 67'(st_r[LAST-1].pr[i][0][j]) + 67'(st_r[LAST-1].pr[i][1][j])
            + 67'(st_r[LAST-1].pr[i][2][j]) + (67'sd1 <<< (UF-1));
        st_nxt[LAST].a[i][j] = hqr_pkg::ent_t'(acc >>> UF);
      end
    end
  end

  assign out_vld  = vld_r[LAST];
  assign out_rows = st_r[LAST].a;
  assign out_deg  = st_r[LAST].deg_in | st_r[LAST].zd;

endmodule

@@ rtl/householder_qr_3x3.sv @@
// Top level of the 3x3 Householder QR factoriser with positive R diagonal.
// A matrix is taken when start is high and busy is low; busy then stays high while
// an internal counter runs down, which spaces matrices to match the result port,
// where the three row words of each matrix follow one another back to back. Matrices
// are pipelined, so a new one can be taken before earlier ones reach the output.
// The result latency is set by the two reflection pipelines, each holding two
// bit-serial square roots and a bit-serial divider. Results cannot be held off.
module householder_qr_3x3 (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [hqr_pkg::DATA_WIDTH-1:0]   in_m_r0_c0,
  input  logic signed [hqr_pkg::DATA_WIDTH-1:0]   in_m_r0_c1,
  input  logic signed [hqr_pkg::DATA_WIDTH-1:0]   in_m_r0_c2,
  input  logic signed [hqr_pkg::DATA_WIDTH-1:0]   in_m_r1_c0,
  input  logic signed [hqr_pkg::DATA_WIDTH-1:0]   in_m_r1_c1,
  input  logic signed [hqr_pkg::DATA_WIDTH-1:0]   in_m_r1_c2,
  input  logic signed [hqr_pkg::DATA_WIDTH-1:0]   in_m_r2_c0,
  input  logic signed [hqr_pkg::DATA_WIDTH-1:0]   in_m_r2_c1,
  input  logic signed [hqr_pkg::DATA_WIDTH-1:0]   in_m_r2_c2,
  output logic                                    out_valid,
  output logic [1:0]                              out_row_index,
  output logic signed [hqr_pkg::DATA_WIDTH-1:0]   out_q_c0,
  output logic signed [hqr_pkg::DATA_WIDTH-1:0]   out_q_c1,
  output logic signed [hqr_pkg::DATA_WIDTH-1:0]   out_q_c2,
  output logic signed [hqr_pkg::DATA_WIDTH-1:0]   out_tri_c0,
  output logic signed [hqr_pkg::DATA_WIDTH-1:0]   out_tri_c1,
  output logic signed [hqr_pkg::DATA_WIDTH-1:0]   out_tri_c2,
  output logic                                    out_degenerate,
  output logic                                    out_last_row
);

  localparam int DW = hqr_pkg::DATA_WIDTH;
  localparam int QS = hqr_pkg::UNIT_FRAC - hqr_pkg::FRAC_BITS;
  localparam hqr_pkg::ent_t SAT_HI = hqr_pkg::ent_t'({1'b0, {(DW-1){1'b1}}});
  localparam hqr_pkg::ent_t SAT_LO = -SAT_HI - hqr_pkg::ent_t'(1);

  logic [1:0]           cnt_r;
  logic                 accept;
  hqr_pkg::ent_t        m_in [3][3];
  hqr_pkg::rows_t       rows_a;
  hqr_pkg::col_t        col_a;
  hqr_pkg::rows_t       res_a;
  logic                 vld_a;
  logic                 deg_a;
  hqr_pkg::rows_t       rows_b;
  hqr_pkg::col_t        col_b;
  hqr_pkg::rows_t       res_b;
  logic                 vld_b;
  logic                 deg_b;
  hqr_pkg::ent_t        rf [3][6];
  logic signed [DW-1:0] fq [3][3];
  logic signed [DW-1:0] ft [3][3];
  logic signed [DW-1:0] hq_r [3][3];
  logic signed [DW-1:0] ht_r [3][3];
  logic                 hdeg_r;
  logic [1:0]           row_r;
  logic                 out_valid_r;

  assign busy   = (cnt_r != 2'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (accept) begin
      cnt_r <= 2'd2;
    end else if (cnt_r != 2'd0) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  assign m_in[0][0] = hqr_pkg::ent_t'(in_m_r0_c0);
  assign m_in[0][1] = hqr_pkg::ent_t'(in_m_r0_c1);
  assign m_in[0][2] = hqr_pkg::ent_t'(in_m_r0_c2);
  assign m_in[1][0] = hqr_pkg::ent_t'(in_m_r1_c0);
  assign m_in[1][1] = hqr_pkg::ent_t'(in_m_r1_c1);
  assign m_in[1][2] = hqr_pkg::ent_t'(in_m_r1_c2);
  assign m_in[2][0] = hqr_pkg::ent_t'(in_m_r2_c0);
  assign m_in[2][1] = hqr_pkg::ent_t'(in_m_r2_c1);
  assign m_in[2][2] = hqr_pkg::ent_t'(in_m_r2_c2);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      col_a[i] = m_in[i][0];
      for (int j = 0; j < 3; j++) begin
        rows_a[i][j] = m_in[i][j];
        rows_a[i][3+j] = (i == j) ? (hqr_pkg::ent_t'(1) <<< hqr_pkg::UNIT_FRAC)
                                  : hqr_pkg::ent_t'(0);
      end
    end
  end

  hqr_reflect u_refl_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .in_rows  (rows_a),
    .in_col   (col_a),
    .in_deg   (1'b0),
    .out_vld  (vld_a),
    .out_rows (res_a),
    .out_deg  (deg_a)
  );

  // The second reflection works on rows 1 and 2, with row 0 riding in the spare lane.
  always_comb begin
    rows_b[0] = res_a[1];
    rows_b[1] = res_a[2];
    rows_b[2] = res_a[0];
    rows_b[0][0] = '0;
    rows_b[1][0] = '0;
    col_b[0] = res_a[1][1];
    col_b[1] = res_a[2][1];
    col_b[2] = '0;
  end

  hqr_reflect u_refl_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_a),
    .in_rows  (rows_b),
    .in_col   (col_b),
    .in_deg   (deg_a),
    .out_vld  (vld_b),
    .out_rows (res_b),
    .out_deg  (deg_b)
  );

  always_comb begin : conv_c
    logic          neg;
    hqr_pkg::ent_t rv;
    hqr_pkg::ent_t qv;
    rf[0] = res_b[2];
    rf[1] = res_b[0];
    rf[2] = res_b[1];
    rf[2][1] = '0;
    for (int i = 0; i < 3; i++) begin
      neg = rf[i][i][hqr_pkg::EW-1];
      for (int j = 0; j < 3; j++) begin
        rv = neg ? -rf[i][j] : rf[i][j];
        qv = neg ? -rf[i][3+j] : rf[i][3+j];
        fq[i][j] = DW'((qv + (hqr_pkg::ent_t'(1) <<< (QS-1))) >>> QS);
        if (rv > SAT_HI) begin
          ft[i][j] = DW'(SAT_HI);
        end else if (rv < SAT_LO) begin
          ft[i][j] = DW'(SAT_LO);
        end else begin
          ft[i][j] = DW'(rv);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld_b) begin
      hq_r   <= fq;
      ht_r   <= ft;
      hdeg_r <= deg_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      row_r       <= 2'd0;
    end else if (vld_b) begin
      out_valid_r <= 1'b1;
      row_r       <= 2'd0;
    end else if (out_valid_r && row_r != 2'd2) begin
      row_r <= row_r + 2'd1;
    end else begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_index  = row_r;
  assign out_last_row   = (row_r == 2'd2);
  assign out_degenerate = hdeg_r;
  assign out_q_c0       = hq_r[row_r][0];
  assign out_q_c1       = hq_r[row_r][1];
  assign out_q_c2       = hq_r[row_r][2];
  assign out_tri_c0     = ht_r[row_r][0];
  assign out_tri_c1     = ht_r[row_r][1];
  assign out_tri_c2     = ht_r[row_r][2];

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after a matrix was taken");

  a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |=> out_valid && out_row_index == $past(out_row_index) + 2'd1)
    else $error("row words of one matrix not contiguous");

  a_deg_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |=> out_degenerate == $past(out_degenerate))
    else $error("degenerate flag changed within one matrix");

  a_new_matrix_row0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_row |=> !out_valid || out_row_index == 2'd0)
    else $error("matrix did not start at row zero");
`endif

endmodule
